FILE: rtl/ecm_pkg.sv
// Package for the Euler-angle camera matrix unit.
// Holds fixed-point constants, the sine table function and shared types.
// No dependencies.
package ecm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int QW = $clog2(SINE_TABLE_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUARTER_TURN = SINE_TABLE_DEPTH / 4;

  typedef enum logic [2:0] {
    ORD_XYZ = 3'd0,
    ORD_YXZ = 3'd1,
    ORD_XZY = 3'd2,
    ORD_YZX = 3'd3,
    ORD_ZYX = 3'd4,
    ORD_ZXY = 3'd5,
    ORD_ID6 = 3'd6,
    ORD_ID7 = 3'd7
  } rot_order_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_TRANS,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic [QW-1:0] qz;
    rot_order_t order;
  } front_req_t;

  typedef logic [SINE_TABLE_DEPTH-1:0][31:0] sine_tab_t;

  // Sine of (pi/2)*r/DEPTH in FRAC_BITS fixed point, evaluated at elaboration.
  function automatic logic signed [31:0] sin_quarter(input int r);
    longint x, x2, t, m, s;
    x = (64'sd1686629713 * longint'(r)) >>> QW;
    x2 = (x * x) >>> 30;
    t = 64'sd1 <<< 30;
    for (int i = 0; i < 6; i++) begin
      m = (x2 * t) >>> 30;
      case (i)
        0: m = m / 156;
        1: m = m / 110;
        2: m = m / 72;
        3: m = m / 42;
        4: m = m / 20;
        default: m = m / 6;
      endcase
      t = (64'sd1 <<< 30) - m;
    end
    s = (x * t) >>> 30;
    s = (s + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    return 32'(s);
  endfunction

  // Full-turn sine table built from the quarter wave by quadrant symmetry.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    int f4, quad, rm;
    logic signed [31:0] a, b;
    for (int q = 0; q < SINE_TABLE_DEPTH; q++) begin
      f4 = q * 4;
      quad = (f4 >> QW) & 3;
      rm = f4 & (SINE_TABLE_DEPTH - 1);
      a = sin_quarter(rm);
      b = sin_quarter(SINE_TABLE_DEPTH - rm);
      case (quad)
        0: tab[q] = a;
        1: tab[q] = b;
        2: tab[q] = -a;
        default: tab[q] = -b;
      endcase
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Sine and cosine of a quantized angle; the cosine reads a quarter turn ahead.
  function automatic logic [63:0] sin_cos(input logic [QW-1:0] q);
    logic [QW-1:0] qc;
    qc = q + QW'(QUARTER_TURN);
    return {SINE_TAB[q], SINE_TAB[qc]};
  endfunction

endpackage

FILE: rtl/ecm_if.sv
// Valid/ready channel interfaces for the camera matrix unit.
// Depends on nothing but plain logic types.
interface ecm_req_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0] angle_x;
  logic [15:0] angle_y;
  logic [15:0] angle_z;
  logic [2:0] rot_order;
  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, rot_order,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, rot_order,
                output ready);
endinterface

interface ecm_row_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] row_index;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  logic last_row;
  modport source (output valid, row_index, col0, col1, col2, col3, last_row, input ready);
  modport sink (input valid, row_index, col0, col1, col2, col3, last_row, output ready);
endinterface

FILE: rtl/ecm_front.sv
// Front end: accepts requests, quantizes angles and queues them.
// Depends on ecm_pkg and ecm_req_if.
module ecm_front import ecm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ecm_req_if.sink     req,
  output front_req_t  head,
  output logic        head_valid,
  input  logic        head_take
);

  front_req_t slots [QUEUE_DEPTH];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;
  front_req_t entry;

  assign req.ready = (count != 2'(QUEUE_DEPTH));
  assign push = req.valid && req.ready;
  assign pop = head_take && head_valid;
  assign head_valid = (count != 2'd0);
  assign head = slots[rd_ptr];

  always_comb begin
    entry.pos_x = req.pos_x;
    entry.pos_y = req.pos_y;
    entry.pos_z = req.pos_z;
    entry.qx = req.angle_x[15 -: QW];
    entry.qy = req.angle_y[15 -: QW];
    entry.qz = req.angle_z[15 -: QW];
    entry.order = rot_order_t'(req.rot_order);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1) else $error("count slip");
`endif

endmodule

FILE: rtl/ecm_back.sv
// Back end: builds the rotation, applies translation and emits four rows.
// Depends on ecm_pkg and ecm_row_if.
module ecm_back import ecm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  front_req_t  head,
  input  logic        head_valid,
  output logic        head_take,
  ecm_row_if.source   row
);

  back_state_t state, state_next;
  logic [1:0] cnt, cnt_next;
  logic [1:0] emit_row;
  logic signed [31:0] ma [3][3];
  logic signed [31:0] mb [3][3];
  logic signed [31:0] mc [3][3];
  logic signed [31:0] rot [3][3];
  logic signed [31:0] trow [3];
  logic signed [31:0] px, py, pz;
  logic identity;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  logic signed [31:0] bx [3][3], by [3][3], bz [3][3];
  logic signed [31:0] prod_row [3];
  logic signed [31:0] tr_val [3];
  logic load_rows, do_mul1, do_mul2, do_trans;
  logic out_valid;
  logic [1:0] out_idx;
  logic signed [31:0] oc0, oc1, oc2, oc3;
  logic out_last;
  logic out_free;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] rnd(input logic signed [65:0] v);
    logic signed [65:0] b;
    b = v + (66'sd1 <<< (FRAC_BITS - 1));
    return 32'(b >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    logic signed [65:0] b;
    b = (v + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (b > 66'sd2147483647) return 32'sh7fffffff;
    if (b < -66'sd2147483648) return 32'sh80000000;
    return b[31:0];
  endfunction

  always_comb begin
    logic [63:0] t;
    t = sin_cos(head.qx); sx = -$signed(t[63:32]); cx = $signed(t[31:0]);
    t = sin_cos(head.qy); sy = -$signed(t[63:32]); cy = $signed(t[31:0]);
    t = sin_cos(head.qz); sz = -$signed(t[63:32]); cz = $signed(t[31:0]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        bx[i][j] = (i == j) ? ONE : 32'sd0;
        by[i][j] = (i == j) ? ONE : 32'sd0;
        bz[i][j] = (i == j) ? ONE : 32'sd0;
      end
    end
    bx[1][1] = cx; bx[1][2] = sx; bx[2][1] = -sx; bx[2][2] = cx;
    by[0][0] = cy; by[0][2] = -sy; by[2][0] = sy; by[2][2] = cy;
    bz[0][0] = cz; bz[0][1] = sz; bz[1][0] = -sz; bz[1][1] = cz;
  end

  // One output row of a 3x3 product per cycle, row selected by cnt.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_row[j] = rnd(66'(ma[cnt][0] * mb[0][j]) + 66'(ma[cnt][1] * mb[1][j])
                        + 66'(ma[cnt][2] * mb[2][j]));
      tr_val[j] = sat(-(66'(px * rot[0][j]) + 66'(py * rot[1][j])
                        + 66'(pz * rot[2][j])));
    end
  end

  assign out_free = !out_valid || row.ready;
  assign emit_row = cnt;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    head_take = 1'b0;
    load_rows = 1'b0;
    do_mul1 = 1'b0;
    do_mul2 = 1'b0;
    do_trans = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          head_take = 1'b1;
          load_rows = 1'b1;
          cnt_next = 2'd0;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        do_mul1 = 1'b1;
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd2) begin
          cnt_next = 2'd0;
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        do_mul2 = 1'b1;
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd2) begin
          cnt_next = 2'd0;
          state_next = ST_TRANS;
        end
      end
      ST_TRANS: begin
        do_trans = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cnt_next = cnt + 2'd1;
          if (cnt == 2'd3) begin
            cnt_next = 2'd0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= 2'd0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rows) begin
      px <= head.pos_x;
      py <= head.pos_y;
      pz <= head.pos_z;
      identity <= (head.order == ORD_ID6) || (head.order == ORD_ID7);
      case (head.order)
        ORD_XYZ: begin ma <= bx; mb <= by; mc <= bz; end
        ORD_YXZ: begin ma <= by; mb <= bx; mc <= bz; end
        ORD_XZY: begin ma <= bx; mb <= bz; mc <= by; end
        ORD_YZX: begin ma <= by; mb <= bz; mc <= bx; end
        ORD_ZYX: begin ma <= bz; mb <= by; mc <= bx; end
        ORD_ZXY: begin ma <= bz; mb <= bx; mc <= by; end
        default: begin ma <= bx; mb <= by; mc <= bz; end
      endcase
    end
    if (do_mul1) begin
      for (int j = 0; j < 3; j++) ma[cnt][j] <= prod_row[j];
      if (cnt == 2'd2) begin
        mb <= mc;
      end
    end
    if (do_mul2) begin
      for (int j = 0; j < 3; j++) begin
        rot[cnt][j] <= identity ? ((32'(cnt) == j) ? ONE : 32'sd0) : prod_row[j];
      end
    end
    if (do_trans) begin
      for (int j = 0; j < 3; j++) trow[j] <= tr_val[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (row.ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_EMIT && out_free) begin
      out_idx <= emit_row;
      out_last <= (emit_row == 2'd3);
      if (emit_row == 2'd3) begin
        oc0 <= trow[0]; oc1 <= trow[1]; oc2 <= trow[2]; oc3 <= ONE;
      end else begin
        oc0 <= rot[emit_row][0]; oc1 <= rot[emit_row][1];
        oc2 <= rot[emit_row][2]; oc3 <= 32'sd0;
      end
    end
  end

  assign row.valid = out_valid;
  assign row.row_index = out_idx;
  assign row.col0 = oc0;
  assign row.col1 = oc1;
  assign row.col2 = oc2;
  assign row.col3 = oc3;
  assign row.last_row = out_last;

`ifndef SYNTH
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    head_take |-> state == ST_IDLE) else $error("take outside idle");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_idx == 2'd3))) else $error("last flag mismatch");
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |-> emit_row == cnt) else $error("row order slip");
`endif

endmodule

FILE: rtl/euler_camera_matrix_unit.sv
// Euler-angle camera view matrix unit: top level.
// Takes requests of camera position, three binary angles and a rotation order,
// and returns the 4x4 view matrix as four row results, rows 0 to 3.
// The request channel (req) and the row channel (rows) are valid/ready
// interfaces; a transfer happens when valid and ready are both high.
// A two-entry request queue sits between the front end and the back end, so
// new requests are taken while a matrix is still being built or emitted.
// The back end loads a request, forms two 3x3 products (one product row per
// cycle through three shared dot-product lanes), computes the translation row
// and emits four rows; it takes the next queued request only once it is back
// in idle after the last row. Rows leave through an output register; when the
// receiver holds ready low, the row holds and the back end waits.
// Synchronous reset empties the queue and returns the back end to idle with
// no row pending.
// Depends on ecm_pkg, ecm_if, ecm_front and ecm_back.
module euler_camera_matrix_unit import ecm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  ecm_req_if.sink req,
  ecm_row_if.source rows
);

  front_req_t head;
  logic head_valid;
  logic head_take;

  ecm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .head       (head),
    .head_valid (head_valid),
    .head_take  (head_take)
  );

  ecm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_take  (head_take),
    .row        (rows)
  );

endmodule

FILE: tb/tb_ecm_if.sv
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from rtl/ecm_if.sv.
// This file holds the request and row record types used by the checker.
// Depends on no other file.
package tb_ecm_types;
  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
    logic [2:0] rot_order;
  } cam_req_t;

  typedef struct {
    logic [1:0] row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic last_row;
  } view_row_t;
endpackage

FILE: tb/tb_euler_camera_matrix_unit.sv
`timescale 1ns / 1ps
// Testbench for euler_camera_matrix_unit: drives camera requests with bursty gaps,
// stalls the row channel, and checks every row against a view matrix predictor.
// Depends on ecm_pkg, ecm_if, tb_ecm_types and the RTL.
module tb_euler_camera_matrix_unit;
  import ecm_pkg::*;
  import tb_ecm_types::*;

  localparam int FB = 16;
  localparam int DEPTH = 256;

  class view_matrix_board;
    view_row_t pending_rows[$];
    int errors;
    int rows_seen;

    function longint round_q(longint v);
      longint b;
      b = v + (64'sd1 <<< (FB - 1));
      if (b >= 0) return b >>> FB;
      return -((-b + ((64'sd1 <<< FB) - 1)) >>> FB);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint quarter_sine(longint r);
      longint dv[6];
      longint x, x2, t, s;
      dv = '{156, 110, 72, 42, 20, 6};
      x = (64'sd1686629713 * r) / DEPTH;
      x2 = (x * x) >>> 30;
      t = 64'sd1 <<< 30;
      for (int i = 0; i < 6; i++) t = (64'sd1 <<< 30) - (((x2 * t) >>> 30) / dv[i]);
      s = (x * t) >>> 30;
      return (s + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    endfunction

    function void angle_trig(logic [15:0] ang, output longint s, output longint c);
      longint q, f4, quad, rm, a, b;
      q = (longint'(ang) * DEPTH) >>> 16;
      f4 = q * 4;
      quad = (f4 / DEPTH) & 3;
      rm = f4 % DEPTH;
      a = quarter_sine(rm);
      b = quarter_sine(DEPTH - rm);
      case (quad)
        0: begin s = a; c = b; end
        1: begin s = b; c = -a; end
        2: begin s = -a; c = -b; end
        default: begin s = -b; c = a; end
      endcase
    endfunction

    function void mat_mul(longint a[3][3], longint b[3][3], output longint r[3][3]);
      longint acc;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
          r[i][j] = round_q(acc);
        end
    endfunction

    function void note_request(cam_req_t rq);
      longint sx, cx, sy, cy, sz, cz, acc;
      longint mx[3][3], my[3][3], mz[3][3], tmp[3][3], rot[3][3];
      longint p[3];
      longint one;
      view_row_t row;
      one = 64'sd1 <<< FB;
      p[0] = rq.pos_x; p[1] = rq.pos_y; p[2] = rq.pos_z;
      angle_trig(rq.angle_x, sx, cx);
      angle_trig(rq.angle_y, sy, cy);
      angle_trig(rq.angle_z, sz, cz);
      sx = -sx; sy = -sy; sz = -sz;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          mx[i][j] = (i == j) ? one : 0;
          my[i][j] = mx[i][j]; mz[i][j] = mx[i][j]; rot[i][j] = mx[i][j];
        end
      mx[1][1] = cx; mx[1][2] = sx; mx[2][1] = -sx; mx[2][2] = cx;
      my[0][0] = cy; my[0][2] = -sy; my[2][0] = sy; my[2][2] = cy;
      mz[0][0] = cz; mz[0][1] = sz; mz[1][0] = -sz; mz[1][1] = cz;
      case (rot_order_t'(rq.rot_order))
        ORD_XYZ: begin mat_mul(mx, my, tmp); mat_mul(tmp, mz, rot); end
        ORD_YXZ: begin mat_mul(my, mx, tmp); mat_mul(tmp, mz, rot); end
        ORD_XZY: begin mat_mul(mx, mz, tmp); mat_mul(tmp, my, rot); end
        ORD_YZX: begin mat_mul(my, mz, tmp); mat_mul(tmp, mx, rot); end
        ORD_ZYX: begin mat_mul(mz, my, tmp); mat_mul(tmp, mx, rot); end
        ORD_ZXY: begin mat_mul(mz, mx, tmp); mat_mul(tmp, my, rot); end
        default: ;
      endcase
      for (int i = 0; i < 3; i++) begin
        row.row_index = 2'(i);
        row.col0 = 32'(clamp32(rot[i][0]));
        row.col1 = 32'(clamp32(rot[i][1]));
        row.col2 = 32'(clamp32(rot[i][2]));
        row.col3 = '0;
        row.last_row = 1'b0;
        pending_rows.push_back(row);
      end
      row.row_index = 2'd3;
      row.last_row = 1'b1;
      row.col3 = 32'(clamp32(one));
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += (-p[k]) * rot[k][j];
        acc = clamp32(round_q(acc));
        case (j)
          0: row.col0 = 32'(acc);
          1: row.col1 = 32'(acc);
          default: row.col2 = 32'(acc);
        endcase
      end
      pending_rows.push_back(row);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_row(view_row_t got);
      view_row_t exp_row;
      rows_seen++;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row %0d", $time, got.row_index);
        errors++;
        return;
      end
      exp_row = pending_rows.pop_front();
      if (got.row_index !== exp_row.row_index)
        report("row_index", 32'(exp_row.row_index), 32'(got.row_index));
      if (got.col0 !== exp_row.col0) report("col0", exp_row.col0, got.col0);
      if (got.col1 !== exp_row.col1) report("col1", exp_row.col1, got.col1);
      if (got.col2 !== exp_row.col2) report("col2", exp_row.col2, got.col2);
      if (got.col3 !== exp_row.col3) report("col3", exp_row.col3, got.col3);
      if (got.last_row !== exp_row.last_row)
        report("last_row", 32'(exp_row.last_row), 32'(got.last_row));
    endfunction
  endclass

  logic clk;
  logic rst;
  ecm_req_if req (clk);
  ecm_row_if rows (clk);
  view_matrix_board board;
  int sent;
  int burst_left;

  euler_camera_matrix_unit dut (.clk(clk), .rst(rst), .req(req.sink), .rows(rows.source));

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    view_row_t got;
    if (!rst && rows.valid && rows.ready) begin
      got.row_index = rows.row_index;
      got.col0 = rows.col0;
      got.col1 = rows.col1;
      got.col2 = rows.col2;
      got.col3 = rows.col3;
      got.last_row = rows.last_row;
      board.check_row(got);
    end
  end

  always @(posedge clk) begin
    int phase;
    phase = int'(($time / 8) % 200);
    if (rst) rows.ready <= 1'b0;
    else if (phase < 40) rows.ready <= 1'b1;
    else if (phase < 80) rows.ready <= ($urandom_range(0, 3) != 0);
    else rows.ready <= ($urandom_range(0, 1) != 0);
  end

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(cam_req_t rq);
    req.valid <= 1'b1;
    req.pos_x <= rq.pos_x;
    req.pos_y <= rq.pos_y;
    req.pos_z <= rq.pos_z;
    req.angle_x <= rq.angle_x;
    req.angle_y <= rq.angle_y;
    req.angle_z <= rq.angle_z;
    req.rot_order <= rq.rot_order;
    do @(posedge clk); while (!req.ready);
    board.note_request(rq);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end
  endtask

  initial begin
    cam_req_t rq;
    int waited;
    board = new();
    sent = 0;
    burst_left = 0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.pos_x <= '0;
    req.pos_y <= '0;
    req.pos_z <= '0;
    req.angle_x <= '0;
    req.angle_y <= '0;
    req.angle_z <= '0;
    req.rot_order <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 24; i++) begin
      rq.rot_order = 3'(i % 8);
      rq.pos_x = (i % 3 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      rq.pos_y = (i % 4 == 1) ? 32'h0 : 32'h8000_0000;
      rq.pos_z = (i % 2 == 0) ? 32'h7fff_ffff : 32'hffff_ffff;
      rq.angle_x = (i < 8) ? 16'h0000 : (i < 16 ? 16'hffff : 16'h4000 * 16'(i % 4));
      rq.angle_y = (i < 8) ? 16'h4000 : (i < 16 ? 16'h8000 : 16'h00ff);
      rq.angle_z = (i < 8) ? 16'hc000 : (i < 16 ? 16'h3fff : 16'hff00);
      send_request(rq);
    end

    for (int i = 0; i < 440; i++) begin
      rq.pos_x = rand_pos();
      rq.pos_y = rand_pos();
      rq.pos_z = rand_pos();
      rq.angle_x = 16'($urandom);
      rq.angle_y = 16'($urandom);
      rq.angle_z = 16'($urandom);
      rq.rot_order = 3'($urandom_range(0, 7));
      send_request(rq);
    end
    req.valid <= 1'b0;

    waited = 0;
    while (board.pending_rows.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    $display("Sent %0d camera requests over all rotation orders; checked %0d rows.",
             sent, board.rows_seen);
    if (board.errors == 0 && board.pending_rows.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
